### src/swtmp_pkg.sv
// Shared constants, register map and helper functions of the square wave
// tone and melody player.
// No dependencies.
package swtmp_pkg;

    // Word field widths
    localparam int MODE_W       = 2;
    localparam int NOTE_PER_W   = 8;
    localparam int COUNT_W      = 16;
    localparam int LEN_W        = 5;
    localparam int NOTES_W      = 64;
    localparam int TABLE_IDX_W  = 4;
    localparam int TABLE_SIZE   = 16;

    // Configuration port geometry: 64-bit registers at 8-byte spacing
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int CFG_SEL_LSB  = 3;
    localparam int CFG_SEL_W    = CFG_ADDR_W - CFG_SEL_LSB;

    // Parameter defaults
    localparam int DEF_MAX_MELODY_NOTES = 16;
    localparam int DEF_PERIOD_BITS      = 8;

    // Command codes carried by the mode field
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NOTE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MELODY = 2'd2;

    // Register indexes
    localparam logic [CFG_SEL_W-1:0] REG_NOTE_TICKS   = 3'd0;
    localparam logic [CFG_SEL_W-1:0] REG_STEP_TICKS   = 3'd1;
    localparam logic [CFG_SEL_W-1:0] REG_MEL_LENGTH   = 3'd2;
    localparam logic [CFG_SEL_W-1:0] REG_NOTES_LOW    = 3'd3;
    localparam logic [CFG_SEL_W-1:0] REG_NOTES_HIGH   = 3'd4;

    // Register reset values
    localparam logic [COUNT_W-1:0] RST_NOTE_TICKS = 16'd400;
    localparam logic [COUNT_W-1:0] RST_STEP_TICKS = 16'd1250;
    localparam logic [LEN_W-1:0]   RST_MEL_LENGTH = 5'd16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Pick one 8-bit note period out of the two packed table registers
    function automatic logic [NOTE_PER_W-1:0] table_note(
        input logic [NOTES_W-1:0]     notes_low,
        input logic [NOTES_W-1:0]     notes_high,
        input logic [TABLE_IDX_W-1:0] idx
    );
        logic [2*NOTES_W-1:0] notes_all;
        notes_all = {notes_high, notes_low};
        return notes_all[{idx, 3'b000} +: NOTE_PER_W];
    endfunction

    // Clamp the melody length into 1 .. max_notes
    function automatic logic [LEN_W-1:0] eff_length(
        input logic [LEN_W-1:0] len,
        input logic [LEN_W-1:0] max_notes
    );
        logic [LEN_W-1:0] n;
        n = len;
        if (n == '0)
        begin
            n = LEN_W'(1);
        end
        if (n > max_notes)
        begin
            n = max_notes;
        end
        return n;
    endfunction

endpackage

### src/square_wave_tone_and_melody_player.sv
// Top level of the square wave tone and melody player: APB register file,
// tick counters, phase machine and output word register.
// Depends on swtmp_pkg.
//
// Each input word is a tick, a play-note command or a start-melody command,
// and each one yields exactly one output word holding the speaker level and
// status. A word is taken every clock cycle while in_stall is low: the
// counters, the phase machine and the output register all update in the cycle
// the word is accepted, and the throughput is one word per cycle unless
// stalled; in_stall rises only while the output register holds a word that
// the sink stalls. Registers are 64 bits wide at byte addresses 0, 8, 16,
// 24, 32 and should be written only while the block is idle.
module square_wave_tone_and_melody_player #(
    parameter int MAX_MELODY_NOTES = swtmp_pkg::DEF_MAX_MELODY_NOTES,
    parameter int PERIOD_BITS      = swtmp_pkg::DEF_PERIOD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swtmp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [swtmp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [swtmp_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,

    // Command words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [swtmp_pkg::MODE_W-1:0]        mode,
    input  logic [swtmp_pkg::NOTE_PER_W-1:0]    note_period,

    // Status words
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                speaker,
    output logic                                sounding,
    output logic                                melody_active
);

    localparam int POS_W  = (MAX_MELODY_NOTES > 1) ? $clog2(MAX_MELODY_NOTES) : 1;
    localparam int WAVE_W = PERIOD_BITS + 1;
    localparam int HALF_W = PERIOD_BITS - 1;
    localparam logic [swtmp_pkg::LEN_W-1:0] MAX_LEN = swtmp_pkg::LEN_W'(MAX_MELODY_NOTES);
    localparam logic [WAVE_W-1:0] WAVE_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WAIT   = 3'd1,
        PH_CHECK  = 3'd2,
        PH_LOW    = 3'd3,
        PH_HIGH   = 3'd4
    } phase_t;

    // Configuration registers
    logic [swtmp_pkg::COUNT_W-1:0]  note_ticks_reg;
    logic [swtmp_pkg::COUNT_W-1:0]  step_ticks_reg;
    logic [swtmp_pkg::LEN_W-1:0]    mel_length_reg;
    logic [swtmp_pkg::NOTES_W-1:0]  notes_low_reg;
    logic [swtmp_pkg::NOTES_W-1:0]  notes_high_reg;

    // Player state
    phase_t                         phase_reg, phase_next;
    logic [WAVE_W-1:0]              wave_reg, wave_next;
    logic [swtmp_pkg::COUNT_W-1:0]  note_el_reg, note_el_next;
    logic [swtmp_pkg::COUNT_W-1:0]  mel_el_reg, mel_el_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [PERIOD_BITS-1:0]         cur_period_reg, cur_period_next;
    logic [HALF_W-1:0]              half_reg, half_next;
    logic                           in_melody_reg, in_melody_next;
    logic                           pin_reg, pin_next;

    // Output word register
    logic                           out_valid_reg;
    logic                           speaker_reg;
    logic                           sounding_reg;
    logic                           melody_reg;

    logic                           cfg_write;
    logic [swtmp_pkg::CFG_SEL_W-1:0] cfg_sel;
    logic                           accept;

    // Tick helpers
    logic [WAVE_W-1:0]              wave_inc;
    logic [swtmp_pkg::COUNT_W-1:0]  note_inc;
    logic [swtmp_pkg::COUNT_W-1:0]  mel_inc;
    logic [swtmp_pkg::LEN_W-1:0]    pos_plus;
    logic [swtmp_pkg::LEN_W-1:0]    len_eff;
    logic [PERIOD_BITS-1:0]         new_period;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[swtmp_pkg::CFG_ADDR_W-1:swtmp_pkg::CFG_SEL_LSB];
    assign cfg_write = psel && penable && pwrite && pready;

    // Read back the selected register
    always_comb
    begin
        unique case (cfg_sel)
            swtmp_pkg::REG_NOTE_TICKS: prdata = swtmp_pkg::CFG_DATA_W'(note_ticks_reg);
            swtmp_pkg::REG_STEP_TICKS: prdata = swtmp_pkg::CFG_DATA_W'(step_ticks_reg);
            swtmp_pkg::REG_MEL_LENGTH: prdata = swtmp_pkg::CFG_DATA_W'(mel_length_reg);
            swtmp_pkg::REG_NOTES_LOW:  prdata = notes_low_reg;
            swtmp_pkg::REG_NOTES_HIGH: prdata = notes_high_reg;
            default:                   prdata = '0;
        endcase
    end

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_ticks_reg <= swtmp_pkg::RST_NOTE_TICKS;
            step_ticks_reg <= swtmp_pkg::RST_STEP_TICKS;
            mel_length_reg <= swtmp_pkg::RST_MEL_LENGTH;
            notes_low_reg  <= '0;
            notes_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                swtmp_pkg::REG_NOTE_TICKS:
                    note_ticks_reg <= pwdata[swtmp_pkg::COUNT_W-1:0];
                swtmp_pkg::REG_STEP_TICKS:
                    step_ticks_reg <= pwdata[swtmp_pkg::COUNT_W-1:0];
                swtmp_pkg::REG_MEL_LENGTH:
                    mel_length_reg <= pwdata[swtmp_pkg::LEN_W-1:0];
                swtmp_pkg::REG_NOTES_LOW:
                    notes_low_reg  <= pwdata;
                swtmp_pkg::REG_NOTES_HIGH:
                    notes_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Handshake: hold off only while a finished word is stalled at the output
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign speaker       = speaker_reg;
    assign sounding      = sounding_reg;
    assign melody_active = melody_reg;

    // Saturating tick counters and the melody index
    assign wave_inc = (wave_reg < WAVE_MAX) ? wave_reg + 1'b1 : WAVE_MAX;
    assign note_inc = (note_el_reg < swtmp_pkg::COUNT_MAX) ? note_el_reg + 1'b1
                                                          : swtmp_pkg::COUNT_MAX;
    assign mel_inc  = (mel_el_reg < swtmp_pkg::COUNT_MAX) ? mel_el_reg + 1'b1
                                                         : swtmp_pkg::COUNT_MAX;
    assign pos_plus = swtmp_pkg::LEN_W'(pos_reg) + 1'b1;
    assign len_eff  = swtmp_pkg::eff_length(mel_length_reg, MAX_LEN);

    // Pick the period of the note about to start
    always_comb
    begin
        case (mode)
            swtmp_pkg::MODE_NOTE:
                new_period = PERIOD_BITS'(note_period);
            swtmp_pkg::MODE_MELODY:
                new_period = PERIOD_BITS'(swtmp_pkg::table_note(
                    notes_low_reg, notes_high_reg, '0));
            default:
                new_period = PERIOD_BITS'(swtmp_pkg::table_note(
                    notes_low_reg, notes_high_reg,
                    swtmp_pkg::TABLE_IDX_W'(pos_plus)));
        endcase
    end

    // Advance counters and step the phase machine
    always_comb
    begin
        phase_next      = phase_reg;
        wave_next       = wave_reg;
        note_el_next    = note_el_reg;
        mel_el_next     = mel_el_reg;
        pos_next        = pos_reg;
        cur_period_next = cur_period_reg;
        half_next       = half_reg;
        in_melody_next  = in_melody_reg;
        pin_next        = pin_reg;

        case (mode)
            swtmp_pkg::MODE_TICK:
            begin
                wave_next    = wave_inc;
                note_el_next = note_inc;
                mel_el_next  = mel_inc;
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        if (mel_inc >= step_ticks_reg)
                        begin
                            mel_el_next = '0;
                            // Stop after the last note, before indexing past it
                            if (pos_plus >= len_eff)
                            begin
                                in_melody_next = 1'b0;
                                phase_next     = PH_IDLE;
                            end
                            else
                            begin
                                pos_next        = POS_W'(pos_plus);
                                phase_next      = PH_CHECK;
                                cur_period_next = new_period;
                                half_next       = new_period[PERIOD_BITS-1:1];
                                note_el_next    = '0;
                            end
                        end
                    end
                    PH_CHECK:
                    begin
                        if (note_inc >= note_ticks_reg)
                        begin
                            note_el_next = '0;
                            phase_next   = in_melody_reg ? PH_WAIT : PH_IDLE;
                        end
                        else
                        begin
                            wave_next  = '0;
                            phase_next = PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        if (wave_inc >= WAVE_W'(half_reg))
                        begin
                            pin_next   = 1'b1;
                            phase_next = PH_HIGH;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (wave_inc >= WAVE_W'(cur_period_reg))
                        begin
                            pin_next   = 1'b0;
                            phase_next = PH_CHECK;
                        end
                    end
                    default:
                    begin
                        pin_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            swtmp_pkg::MODE_NOTE:
            begin
                phase_next      = PH_CHECK;
                cur_period_next = new_period;
                half_next       = new_period[PERIOD_BITS-1:1];
                note_el_next    = '0;
            end
            swtmp_pkg::MODE_MELODY:
            begin
                in_melody_next  = 1'b1;
                pos_next        = '0;
                mel_el_next     = '0;
                phase_next      = PH_CHECK;
                cur_period_next = new_period;
                half_next       = new_period[PERIOD_BITS-1:1];
                note_el_next    = '0;
            end
            default: ;
        endcase
    end

    // Hold player state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            wave_reg       <= '0;
            note_el_reg    <= '0;
            mel_el_reg     <= '0;
            pos_reg        <= '0;
            cur_period_reg <= '0;
            half_reg       <= '0;
            in_melody_reg  <= 1'b0;
            pin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                wave_reg       <= wave_next;
                note_el_reg    <= note_el_next;
                mel_el_reg     <= mel_el_next;
                pos_reg        <= pos_next;
                cur_period_reg <= cur_period_next;
                half_reg       <= half_next;
                in_melody_reg  <= in_melody_next;
                pin_reg        <= pin_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speaker_reg  <= pin_next;
            sounding_reg <= (phase_next == PH_CHECK) || (phase_next == PH_LOW)
                            || (phase_next == PH_HIGH);
            melody_reg   <= in_melody_next;
        end
    end

endmodule

### tb/tb.sv
// Self-checking testbench of square_wave_tone_and_melody_player: a directed table of
// command words, then random phases of note, melody and noise sequences under
// random stalls, all checked against a cycle-free model of the player.
// Depends on swtmp_pkg and the player RTL.
module tb;

    localparam logic [swtmp_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;

    // Player phases
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_MELODY_WAIT = 3'd1;
    localparam logic [2:0] PH_NOTE_CHECK  = 3'd2;
    localparam logic [2:0] PH_LOW_HALF    = 3'd3;
    localparam logic [2:0] PH_HIGH_HALF   = 3'd4;

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 130;
    localparam int SCRIPT_ROWS   = 18;

    typedef struct packed {
        logic speaker;
        logic sounding;
        logic melody_active;
    } status_t;

    typedef struct packed {
        logic                             is_cfg;
        logic [swtmp_pkg::CFG_SEL_W-1:0]  reg_idx;
        logic [63:0]                      value;
        logic [swtmp_pkg::MODE_W-1:0]     op;
        logic [7:0]                       period;
        logic [3:0]                       reps;
        logic                             typed;
        status_t                          want;
    } script_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [swtmp_pkg::CFG_ADDR_W-1:0]    paddr;
    logic [swtmp_pkg::CFG_DATA_W-1:0]    pwdata;
    logic [swtmp_pkg::CFG_DATA_W-1:0]    prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_stall;
    logic [swtmp_pkg::MODE_W-1:0]        mode;
    logic [swtmp_pkg::NOTE_PER_W-1:0]    note_period;
    logic                                out_valid;
    logic                                out_stall;
    logic                                speaker;
    logic                                sounding;
    logic                                melody_active;

    // Player model: registers and state
    logic [15:0]                         cfg_note_ticks;
    logic [15:0]                         cfg_step_ticks;
    logic [4:0]                          cfg_length;
    logic [63:0]                         cfg_notes_low;
    logic [63:0]                         cfg_notes_high;
    logic [2:0]                          ph;
    logic [swtmp_pkg::DEF_PERIOD_BITS:0] wave_cnt;
    logic [15:0]                         note_cnt;
    logic [15:0]                         step_cnt;
    logic [4:0]                          mel_pos;
    logic [7:0]                          cur_period;
    logic [6:0]                          half_period;
    logic                                in_melody;
    logic                                pin;

    status_t                expected_status[$];
    script_row_t            directed_rows [0:SCRIPT_ROWS-1];

    bit                     calm = 1'b0;
    bit                     long_hold = 1'b0;
    int                     fail_count = 0;
    int                     idle_cycles = 0;
    int                     words_sent = 0;
    int                     words_checked = 0;
    int                     notes_started = 0;
    int                     melodies_started = 0;
    int                     melodies_done = 0;
    int                     settings_used = 0;

    square_wave_tone_and_melody_player dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .note_period   (note_period),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .speaker       (speaker),
        .sounding      (sounding),
        .melody_active (melody_active)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Period of one melody table entry
    function automatic logic [7:0] melody_entry(input logic [4:0] idx);
        logic [5:0] bit_pos;
        bit_pos = {idx[2:0], 3'b000};
        return idx[3] ? cfg_notes_high[bit_pos +: 8] : cfg_notes_low[bit_pos +: 8];
    endfunction

    // Mostly short periods, now and then any byte
    function automatic logic [7:0] rand_period();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 12));
    endfunction

    task automatic begin_note(input logic [7:0] per);
        ph          = PH_NOTE_CHECK;
        cur_period  = per;
        half_period = per[7:1];
        note_cnt    = '0;
    endtask

    // Advance the player model by one command word and give its status
    task automatic predict_word(input logic [swtmp_pkg::MODE_W-1:0] op,
                                input logic [7:0] per, output status_t st);
        int notes_in_table;
        notes_in_table = (cfg_length == 0) ? 1 :
                         (cfg_length > swtmp_pkg::DEF_MAX_MELODY_NOTES) ?
                         swtmp_pkg::DEF_MAX_MELODY_NOTES : int'(cfg_length);
        case (op)
            swtmp_pkg::MODE_TICK:
            begin
                // Advance the saturating counters, then step the phase machine
                if (wave_cnt != '1)
                    wave_cnt = wave_cnt + 1'b1;
                if (note_cnt != '1)
                    note_cnt = note_cnt + 1'b1;
                if (step_cnt != '1)
                    step_cnt = step_cnt + 1'b1;
                case (ph)
                    PH_MELODY_WAIT:
                    begin
                        if (step_cnt >= cfg_step_ticks)
                        begin
                            step_cnt = '0;
                            if (int'(mel_pos) + 1 >= notes_in_table)
                            begin
                                in_melody = 1'b0;
                                ph = PH_IDLE;
                                melodies_done++;
                            end
                            else
                            begin
                                mel_pos = mel_pos + 1'b1;
                                begin_note(melody_entry(mel_pos));
                            end
                        end
                    end
                    PH_NOTE_CHECK:
                    begin
                        if (note_cnt >= cfg_note_ticks)
                        begin
                            note_cnt = '0;
                            ph = in_melody ? PH_MELODY_WAIT : PH_IDLE;
                        end
                        else
                        begin
                            wave_cnt = '0;
                            ph = PH_LOW_HALF;
                        end
                    end
                    PH_LOW_HALF:
                    begin
                        if (wave_cnt >= half_period)
                        begin
                            pin = 1'b1;
                            ph = PH_HIGH_HALF;
                        end
                    end
                    PH_HIGH_HALF:
                    begin
                        if (wave_cnt >= cur_period)
                        begin
                            pin = 1'b0;
                            ph = PH_NOTE_CHECK;
                        end
                    end
                    default:
                    begin
                        pin = 1'b0;
                        ph = PH_IDLE;
                    end
                endcase
            end
            swtmp_pkg::MODE_NOTE:
            begin
                begin_note(per);
                notes_started++;
            end
            swtmp_pkg::MODE_MELODY:
            begin
                in_melody = 1'b1;
                mel_pos   = '0;
                step_cnt  = '0;
                begin_note(melody_entry(5'd0));
                melodies_started++;
            end
            default:
            begin
            end
        endcase
        st.speaker       = pin;
        st.sounding      = (ph >= PH_NOTE_CHECK) && (ph <= PH_HIGH_HALF);
        st.melody_active = in_melody;
    endtask

    // Offer one word, hold it until taken, and log its expected status
    task automatic send_word(input logic [swtmp_pkg::MODE_W-1:0] op, input logic [7:0] per,
                             input logic typed, input status_t want);
        status_t predicted;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        note_period <= per;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(op, per, predicted);
        expected_status.push_back(typed ? want : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected status word is back
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Write one register: setup cycle, then access cycle
    task automatic write_reg(input logic [swtmp_pkg::CFG_SEL_W-1:0] idx,
                             input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {swtmp_pkg::CFG_SEL_LSB{1'b0}}};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            swtmp_pkg::REG_NOTE_TICKS: cfg_note_ticks = val[15:0];
            swtmp_pkg::REG_STEP_TICKS: cfg_step_ticks = val[15:0];
            swtmp_pkg::REG_MEL_LENGTH: cfg_length     = val[4:0];
            swtmp_pkg::REG_NOTES_LOW:  cfg_notes_low  = val;
            swtmp_pkg::REG_NOTES_HIGH: cfg_notes_high = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Sink side: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each status word taken with the oldest expectation
    always @(posedge clk)
    begin : status_check
        status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status word with none expected: speaker %0b sounding %0b melody %0b",
                       speaker, sounding, melody_active);
                fail_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                words_checked++;
                if (speaker !== want.speaker)
                begin
                    $error("speaker: expected %0b, got %0b", want.speaker, speaker);
                    fail_count++;
                end
                if (sounding !== want.sounding)
                begin
                    $error("sounding: expected %0b, got %0b", want.sounding, sounding);
                    fail_count++;
                end
                if (melody_active !== want.melody_active)
                begin
                    $error("melody_active: expected %0b, got %0b",
                           want.melody_active, melody_active);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("** square_wave_tone_and_melody_player: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] nt;
        logic [15:0] st;
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        int          made;
        int          n;
        int          burst;
        int          pick;
        bit          hold_done;
        bit          pause_done;

        hold_done   = 1'b0;
        pause_done  = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        mode        = swtmp_pkg::MODE_TICK;
        note_period = '0;

        // Model state after reset
        cfg_note_ticks = swtmp_pkg::RST_NOTE_TICKS;
        cfg_step_ticks = swtmp_pkg::RST_STEP_TICKS;
        cfg_length     = swtmp_pkg::RST_MEL_LENGTH;
        cfg_notes_low  = '0;
        cfg_notes_high = '0;
        ph             = PH_IDLE;
        wave_cnt       = '0;
        note_cnt       = '0;
        step_cnt       = '0;
        mel_pos        = '0;
        cur_period     = '0;
        half_period    = '0;
        in_melody      = 1'b0;
        pin            = 1'b0;

        // is_cfg, reg, value, op, period, reps, typed, status {speaker, sounding, melody}
        directed_rows = '{
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd1, 1'b1, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              MODE_IGNORED,           8'hFF, 4'd1, 1'b1, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_NOTE,   8'hFF, 4'd1, 1'b1, 3'b010},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd2, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_NOTE,   8'h00, 4'd1, 1'b1, 3'b010},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_TICK,   8'hFF, 4'd3, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_MELODY, 8'h00, 4'd1, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              MODE_IGNORED,           8'hAA, 4'd1, 1'b0, 3'b000},
            '{1'b1, swtmp_pkg::REG_NOTE_TICKS, 64'd1,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd0, 1'b0, 3'b000},
            '{1'b1, swtmp_pkg::REG_STEP_TICKS, 64'd2,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd0, 1'b0, 3'b000},
            '{1'b1, swtmp_pkg::REG_MEL_LENGTH, 64'd2,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd0, 1'b0, 3'b000},
            '{1'b1, swtmp_pkg::REG_NOTES_LOW,  64'h0000_0000_0000_0201,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd0, 1'b0, 3'b000},
            '{1'b1, swtmp_pkg::REG_NOTES_HIGH, 64'hFFFF_FFFF_FFFF_FFFF,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd0, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_MELODY, 8'h55, 4'd1, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd8, 1'b0, 3'b000},
            '{1'b1, swtmp_pkg::REG_MEL_LENGTH, 64'd0,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd0, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_MELODY, 8'h00, 4'd1, 1'b0, 3'b000},
            '{1'b0, swtmp_pkg::REG_NOTE_TICKS, 64'd0,
              swtmp_pkg::MODE_TICK,   8'h00, 4'd4, 1'b0, 3'b000}
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: reset values, period extremes, every command, melody end
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                settle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
                settings_used++;
            end
            else
            begin
                repeat (directed_rows[r].reps)
                    send_word(directed_rows[r].op, directed_rows[r].period,
                              directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random phases, each with its own register setting
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            settle();
            nt  = 16'($urandom_range(1, 40));
            st  = 16'($urandom_range(1, 60));
            len = 5'($urandom_range(0, 31));
            for (int b = 0; b < 8; b++)
            begin
                lo[b*8 +: 8] = rand_period();
                hi[b*8 +: 8] = rand_period();
            end
            case (k)
                0:
                begin
                    nt  = '1;
                    st  = '1;
                    len = 5'd31;
                    lo  = '1;
                    hi  = '1;
                end
                1:
                begin
                    nt  = '0;
                    st  = '0;
                    len = 5'd0;
                    lo  = '0;
                    hi  = '0;
                end
                2:
                begin
                    nt  = 16'd1;
                    st  = 16'd1;
                    len = 5'd1;
                end
                3: len = 5'd16;
                4: len = 5'd17;
                default:
                begin
                end
            endcase
            write_reg(swtmp_pkg::REG_NOTE_TICKS, 64'(nt));
            write_reg(swtmp_pkg::REG_STEP_TICKS, 64'(st));
            write_reg(swtmp_pkg::REG_MEL_LENGTH, 64'(len));
            write_reg(swtmp_pkg::REG_NOTES_LOW, lo);
            write_reg(swtmp_pkg::REG_NOTES_HIGH, hi);
            settings_used++;

            calm = (k == RANDOM_PHASES - 1);
            made = 0;
            // Let the wave counter run into its ceiling
            if (k == 3)
            begin
                repeat (600)
                    send_word(swtmp_pkg::MODE_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
                made += 600;
            end
            while (made < PHASE_WORDS)
            begin
                if (k != RANDOM_PHASES - 1)
                    calm = ($urandom_range(0, 4) == 0);
                if (k == 4 && made >= 80 && !hold_done)
                begin
                    long_hold = 1'b1;
                    hold_done = 1'b1;
                end
                if (k == 5 && made >= 80 && !pause_done)
                begin
                    settle();
                    pause_done = 1'b1;
                end
                pick = $urandom_range(0, 9);
                n = 0;
                if (pick < 3)
                begin
                    send_word(swtmp_pkg::MODE_NOTE, rand_period(), 1'b0, '0);
                    n = $urandom_range(5, 60);
                    made++;
                end
                else if (pick < 6)
                begin
                    send_word(swtmp_pkg::MODE_MELODY, 8'($urandom_range(0, 255)), 1'b0, '0);
                    n = $urandom_range(20, 200);
                    made++;
                end
                else
                begin
                    // Noise: any command, any period
                    burst = $urandom_range(1, 8);
                    repeat (burst)
                        send_word(swtmp_pkg::MODE_W'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)), 1'b0, '0);
                    made += burst;
                end
                repeat (n)
                    send_word(swtmp_pkg::MODE_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
                made += n;
            end
        end

        settle();
        repeat (5) @(posedge clk);

        $display("Run covered %0d command words over %0d register settings:",
                 words_sent, settings_used);
        $display("%0d notes, %0d melodies (%0d played to the end); %0d status words compared, %0d mismatches.",
                 notes_started, melodies_started, melodies_done, words_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("** square_wave_tone_and_melody_player: PASSED **");
        end
        else
        begin
            $display("** square_wave_tone_and_melody_player: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
src/swtmp_pkg.sv
src/square_wave_tone_and_melody_player.sv
tb/tb.sv
